FILE: sv/vfc_pkg.sv
package vfc_pkg;

   // Neighbor coordinates run from -1 to 16, so they carry a sign bit.
   localparam int COORD_W = 6;
   localparam int FACE_COUNT = 6;
   localparam int QUEUE_DEPTH = 2;
   localparam int FLOOR_LAYERS = 8;
   localparam logic [15:0] FLOOR_ID = 16'd1;
   localparam logic [15:0] LIGHT_OUTSIDE = 16'hFFFF;

   // Face order: +z, +x, -z, -x, +y, -y.
   localparam logic signed [1:0] DIR_DX [FACE_COUNT] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd0, 2'sd0};
   localparam logic signed [1:0] DIR_DY [FACE_COUNT] = '{2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1, -2'sd1};
   localparam logic signed [1:0] DIR_DZ [FACE_COUNT] = '{2'sd1, 2'sd0, -2'sd1, 2'sd0, 2'sd0, 2'sd0};

   typedef enum logic [1:0] {
      OP_WR_VOXEL = 2'd0,
      OP_WR_LIGHT = 2'd1,
      OP_RD_VOXEL = 2'd2,
      OP_QUERY    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_CHUNK_X = 2'd0,
      CSR_CHUNK_Y = 2'd1,
      CSR_CHUNK_Z = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_READ,
      BK_SCAN,
      BK_EMIT
   } bk_state_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  pos_x;
      logic [3:0]  pos_y;
      logic [3:0]  pos_z;
      logic [31:0] write_word;
   } req_type;

   typedef struct packed {
      logic [31:0]        read_word;
      logic               face_valid;
      logic [2:0]         face_dir;
      logic signed [15:0] world_x;
      logic signed [15:0] world_y;
      logic signed [15:0] world_z;
      logic [15:0]        block_id;
      logic [15:0]        neighbor_light;
      logic               last;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic        in_grid;
      logic [3:0]  pos_x;
      logic [3:0]  pos_y;
      logic [3:0]  pos_z;
      logic [31:0] word;
   } item_type;

   typedef struct packed {
      logic signed [11:0] chunk_x;
      logic signed [11:0] chunk_y;
      logic signed [11:0] chunk_z;
   } cfg_type;

endpackage

FILE: sv/vfc_front.sv
module vfc_front import vfc_pkg::*; #(
   parameter int SIZE_X = 16,
   parameter int SIZE_Y = 16,
   parameter int SIZE_Z = 16
) (
   input  logic     start,
   input  req_type  req_data,
   input  logic     queue_full,
   input  logic     clearing,
   output logic     busy,
   output logic     push,
   output item_type push_item
);

   localparam logic [6:0] SX7 = 7'(SIZE_X);
   localparam logic [6:0] SY7 = 7'(SIZE_Y);
   localparam logic [6:0] SZ7 = 7'(SIZE_Z);

   op_type op;

   assign busy = clearing || queue_full;
   assign push = start && !busy;

   // Every 2-bit command value is a defined operation.
   assign op = op_type'(req_data.command);

   always_comb begin
      push_item.op      = op;
      push_item.in_grid = (7'(req_data.pos_x) < SX7) && (7'(req_data.pos_y) < SY7) &&
                          (7'(req_data.pos_z) < SZ7);
      push_item.pos_x   = req_data.pos_x;
      push_item.pos_y   = req_data.pos_y;
      push_item.pos_z   = req_data.pos_z;
      push_item.word    = req_data.write_word;
   end

endmodule

FILE: sv/vfc_queue.sv
module vfc_queue import vfc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output item_type head,
   output logic     empty,
   output logic     full
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   item_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   assign head  = entry_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("item pushed into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("item popped from an empty queue");
   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == CNT_W'($past(count_ff) + 1'b1))
      else $error("queue count did not follow a push");

endmodule

FILE: sv/vfc_back.sv
module vfc_back import vfc_pkg::*; #(
   parameter int SIZE_X = 16,
   parameter int SIZE_Y = 16,
   parameter int SIZE_Z = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     q_empty,
   input  item_type q_head,
   output logic     q_pop,
   output logic     clearing,
   output logic     rsp_strobe,
   output rsp_type  rsp_data
);

   localparam int XW = $clog2(SIZE_X);
   localparam int YW = $clog2(SIZE_Y);
   localparam int ZW = $clog2(SIZE_Z);
   localparam int AW = XW + YW + ZW;
   localparam int DEPTH = 1 << AW;
   localparam logic [6:0] SX7 = 7'(SIZE_X);
   localparam logic [6:0] SY7 = 7'(SIZE_Y);
   localparam logic [6:0] SZ7 = 7'(SIZE_Z);
   localparam logic [15:0] SX16 = 16'(SIZE_X);
   localparam logic [15:0] SY16 = 16'(SIZE_Y);
   localparam logic [15:0] SZ16 = 16'(SIZE_Z);

   function automatic logic [AW-1:0] cell_addr(input logic [COORD_W-1:0] cx,
                                               input logic [COORD_W-1:0] cy,
                                               input logic [COORD_W-1:0] cz);
      return {cz[ZW-1:0], cy[YW-1:0], cx[XW-1:0]};
   endfunction

   function automatic logic coord_ok(input logic [COORD_W-1:0] c, input logic [6:0] lim);
      return !c[COORD_W-1] && ({1'b0, c} < lim);
   endfunction

   bk_state_type state_ff;
   bk_state_type state_in;
   logic [AW-1:0] clr_addr_ff;
   item_type      cur_ff;
   logic [2:0]    step_ff;
   logic          prev_in_ff;
   logic [15:0]   center_id_ff;
   logic [FACE_COUNT-1:0] open_ff;
   logic [15:0]   light_ff [FACE_COUNT];

   logic [31:0]   voxel_mem_ff [DEPTH];
   logic [15:0]   light_mem_ff [DEPTH];
   logic [31:0]   voxel_rd_ff;
   logic [15:0]   light_rd_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   logic [2:0]          face_idx;
   logic [2:0]          cap_idx;
   logic [COORD_W-1:0]  nbr_x;
   logic [COORD_W-1:0]  nbr_y;
   logic [COORD_W-1:0]  nbr_z;
   logic                nbr_in;
   logic [AW-1:0]       nbr_addr;
   logic [AW-1:0]       head_addr;
   logic                clr_floor;
   logic [2:0]          first_face;
   logic [FACE_COUNT-1:0] open_left;
   logic                no_face;
   logic [15:0]         world_x;
   logic [15:0]         world_y;
   logic [15:0]         world_z;

   logic          vox_we;
   logic [AW-1:0] vox_waddr;
   logic [31:0]   vox_wdata;
   logic          light_we;
   logic [AW-1:0] light_waddr;
   logic [15:0]   light_wdata;
   logic [AW-1:0] rd_addr;
   logic          emit;
   rsp_type       rsp_in;

   assign clearing   = (state_ff == BK_CLEAR);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // At step 6 the face index wraps to 0 and its read goes unused; the step only captures the last neighbor.
   assign face_idx = (step_ff < 3'(FACE_COUNT)) ? step_ff : '0;
   assign cap_idx  = step_ff - 3'd1;
   assign nbr_x    = COORD_W'(cur_ff.pos_x) + COORD_W'(DIR_DX[face_idx]);
   assign nbr_y    = COORD_W'(cur_ff.pos_y) + COORD_W'(DIR_DY[face_idx]);
   assign nbr_z    = COORD_W'(cur_ff.pos_z) + COORD_W'(DIR_DZ[face_idx]);
   assign nbr_in   = coord_ok(nbr_x, SX7) && coord_ok(nbr_y, SY7) && coord_ok(nbr_z, SZ7);
   assign nbr_addr = cell_addr(nbr_x, nbr_y, nbr_z);
   assign head_addr = cell_addr(COORD_W'(q_head.pos_x), COORD_W'(q_head.pos_y),
                                COORD_W'(q_head.pos_z));
   assign clr_floor = (7'(clr_addr_ff[XW +: YW]) < 7'(FLOOR_LAYERS));

   always_comb begin
      first_face = '0;
      for (int i = FACE_COUNT - 1; i >= 0; i--) begin
         if (open_ff[i]) begin
            first_face = 3'(i);
         end
      end
   end

   assign open_left = open_ff & ~(FACE_COUNT'(1) << first_face);
   assign no_face   = (center_id_ff == '0) || (open_ff == '0);

   assign world_x = 16'({{4{cfg.chunk_x[11]}}, cfg.chunk_x} * SX16) + 16'(cur_ff.pos_x);
   assign world_y = 16'({{4{cfg.chunk_y[11]}}, cfg.chunk_y} * SY16) + 16'(cur_ff.pos_y);
   assign world_z = 16'({{4{cfg.chunk_z[11]}}, cfg.chunk_z} * SZ16) + 16'(cur_ff.pos_z);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            if (clr_addr_ff == '1) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!q_empty) begin
               if (q_head.op == OP_RD_VOXEL) begin
                  state_in = BK_READ;
               end else if (q_head.op == OP_QUERY) begin
                  state_in = BK_SCAN;
               end
            end
         end
         BK_READ: state_in = BK_IDLE;
         BK_SCAN: begin
            if (step_ff == 3'(FACE_COUNT)) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (no_face || (open_left == '0)) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop       = 1'b0;
      vox_we      = 1'b0;
      vox_waddr   = head_addr;
      vox_wdata   = q_head.word;
      light_we    = 1'b0;
      light_waddr = head_addr;
      light_wdata = q_head.word[15:0];
      rd_addr     = head_addr;
      emit        = 1'b0;
      rsp_in      = '0;
      unique case (state_ff)
         BK_CLEAR: begin
            vox_we      = 1'b1;
            vox_waddr   = clr_addr_ff;
            vox_wdata   = clr_floor ? 32'(FLOOR_ID) : '0;
            light_we    = 1'b1;
            light_waddr = clr_addr_ff;
            light_wdata = '0;
         end
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               vox_we   = q_head.in_grid && (q_head.op == OP_WR_VOXEL);
               light_we = q_head.in_grid && (q_head.op == OP_WR_LIGHT);
            end
         end
         BK_READ: begin
            emit             = 1'b1;
            rsp_in.read_word = cur_ff.in_grid ? voxel_rd_ff : '0;
            rsp_in.last      = 1'b1;
         end
         BK_SCAN: rd_addr = nbr_addr;
         BK_EMIT: begin
            emit = 1'b1;
            if (no_face) begin
               rsp_in.last = 1'b1;
            end else begin
               rsp_in.face_valid     = 1'b1;
               rsp_in.face_dir       = first_face;
               rsp_in.world_x        = world_x;
               rsp_in.world_y        = world_y;
               rsp_in.world_z        = world_z;
               rsp_in.block_id       = center_id_ff;
               rsp_in.neighbor_light = light_ff[first_face];
               rsp_in.last           = (open_left == '0);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= emit;
         if (state_ff == BK_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
      end
   end

   // Read data is registered, so it arrives in the cycle after its address: step 0 sees the center voxel,
   // step k sees the neighbor issued at step k-1.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (q_pop) begin
         cur_ff  <= q_head;
         step_ff <= '0;
      end else if (state_ff == BK_SCAN) begin
         step_ff    <= step_ff + 1'b1;
         prev_in_ff <= nbr_in;
         if (step_ff == '0) begin
            center_id_ff <= cur_ff.in_grid ? voxel_rd_ff[15:0] : '0;
         end else begin
            open_ff[cap_idx]  <= !(prev_in_ff && (voxel_rd_ff[15:0] != '0));
            light_ff[cap_idx] <= prev_in_ff ? light_rd_ff : LIGHT_OUTSIDE;
         end
      end else if (state_ff == BK_EMIT) begin
         open_ff <= open_left;
      end
   end

   always_ff @(posedge clock) begin
      if (vox_we) begin
         voxel_mem_ff[vox_waddr] <= vox_wdata;
      end
      voxel_rd_ff <= voxel_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (light_we) begin
         light_mem_ff[light_waddr] <= light_wdata;
      end
      light_rd_ff <= light_mem_ff[rd_addr];
   end

   a_quiet_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_CLEAR) |-> !rsp_valid_ff)
      else $error("result issued during the clearing pass");
   a_face_dir: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.face_valid) |-> (rsp_ff.face_dir < 3'(FACE_COUNT)))
      else $error("face result with an unknown direction");
   a_plain_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.face_valid) |-> rsp_ff.last)
      else $error("non-face result not marked last");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.last) |-> (state_ff == BK_IDLE))
      else $error("sequencer still busy after the last result of an item");

endmodule

FILE: sv/voxel_face_culling_core.sv
// Channel   Ports                               Direction  Handshake
// request   start, busy, req_data               in         taken when start && !busy
// result    rsp_strobe, rsp_data                out        one-cycle strobe per result, no stall
// config    csr_we, csr_index, csr_wdata        in         written when csr_we is high
//
// Writes finish in the sequencer's idle state, a read passes through the read state,
// and a face query through scan and emit: the center voxel and six neighbors come
// one per cycle through the single read port of the voxel and light memories.
// After reset a clearing pass over all 2**(clog2(SIZE_X)+clog2(SIZE_Y)+clog2(SIZE_Z))
// cells (4096 by default) holds busy high. A two-item queue sits between the
// request decoder and the sequencer; busy rises when it is full.
module voxel_face_culling_core import vfc_pkg::*; #(
   parameter int SIZE_X = 16,
   parameter int SIZE_Y = 16,
   parameter int SIZE_Z = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata
);

   cfg_type  cfg_ff;
   logic     push;
   item_type push_item;
   logic     pop;
   item_type head;
   logic     q_empty;
   logic     q_full;
   logic     clearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CHUNK_X: cfg_ff.chunk_x <= csr_wdata;
            CSR_CHUNK_Y: cfg_ff.chunk_y <= csr_wdata;
            CSR_CHUNK_Z: cfg_ff.chunk_z <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   vfc_front #(
      .SIZE_X(SIZE_X),
      .SIZE_Y(SIZE_Y),
      .SIZE_Z(SIZE_Z)
   ) u_front (
      .start      (start),
      .req_data   (req_data),
      .queue_full (q_full),
      .clearing   (clearing),
      .busy       (busy),
      .push       (push),
      .push_item  (push_item)
   );

   vfc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .empty     (q_empty),
      .full      (q_full)
   );

   vfc_back #(
      .SIZE_X(SIZE_X),
      .SIZE_Y(SIZE_Y),
      .SIZE_Z(SIZE_Z)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_head     (head),
      .q_pop      (pop),
      .clearing   (clearing),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
